// ===== src/tcw_pkg.sv =====
// Package for the text console character writer.
// Holds the character codes, the operation classes and the queued operation type.
// No dependencies.
package tcw_pkg;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] TAB_MASK     = 8'hF8;

  localparam logic [2:0] FN_PUT      = 3'd0;
  localparam logic [2:0] FN_PUT_POS  = 3'd1;
  localparam logic [2:0] FN_SET      = 3'd2;
  localparam logic [2:0] FN_MOVE     = 3'd3;
  localparam logic [2:0] FN_CLEAR    = 3'd4;
  localparam logic [2:0] FN_SCROLL   = 3'd5;
  localparam logic [2:0] FN_READ     = 3'd6;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    K_NOP,
    K_PRINT,
    K_NEWLINE,
    K_RETURN,
    K_TAB,
    K_BACKSPACE,
    K_PUT_POS,
    K_SET,
    K_MOVE,
    K_CLEAR,
    K_SCROLL,
    K_READ
  } op_kind_e;

  typedef struct packed {
    op_kind_e          kind;
    logic [7:0]        ch;
    logic [7:0]        attr;
    logic [7:0]        x;
    logic [7:0]        y;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } op_t;

endpackage

// ===== src/tcw_front.sv =====
// Front part of the text console writer: accepts items and classifies them.
// Depends on tcw_pkg; feeds tcw_queue.
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        func_i,
  input  logic [7:0]        ch_i,
  input  logic [7:0]        attr_i,
  input  logic [7:0]        col_x_i,
  input  logic [7:0]        row_y_i,
  input  logic signed [7:0] delta_x_i,
  input  logic signed [7:0] delta_y_i,
  input  logic              queue_full_i,
  input  logic              init_busy_i,
  output logic              push_o,
  output tcw_pkg::op_t      op_o
);
  import tcw_pkg::*;

  localparam logic [7:0] ColLimit = 8'(COLUMNS);
  localparam logic [7:0] RowLimit = 8'(ROWS);

  logic in_range;

  assign in_range   = (col_x_i < ColLimit) && (row_y_i < RowLimit);
  assign in_stall_o = queue_full_i || init_busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  always_comb begin
    op_o.ch   = ch_i;
    op_o.attr = attr_i;
    op_o.x    = col_x_i;
    op_o.y    = row_y_i;
    op_o.dx   = delta_x_i;
    op_o.dy   = delta_y_i;
    unique case (func_i)
      FN_PUT: begin
        case (ch_i)
          CH_NEWLINE:   op_o.kind = K_NEWLINE;
          CH_RETURN:    op_o.kind = K_RETURN;
          CH_TAB:       op_o.kind = K_TAB;
          CH_BACKSPACE: op_o.kind = K_BACKSPACE;
          default:      op_o.kind = K_PRINT;
        endcase
      end
      FN_PUT_POS: op_o.kind = in_range ? K_PUT_POS : K_NOP;
      FN_SET:     op_o.kind = in_range ? K_SET : K_NOP;
      FN_MOVE:    op_o.kind = K_MOVE;
      FN_CLEAR:   op_o.kind = K_CLEAR;
      FN_SCROLL:  op_o.kind = K_SCROLL;
      FN_READ:    op_o.kind = in_range ? K_READ : K_NOP;
      default:    op_o.kind = K_NOP;
    endcase
  end

endmodule

// ===== src/tcw_queue.sv =====
// Short operation queue between the front and back parts of the console writer.
// Depends on tcw_pkg.
module tcw_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  tcw_pkg::op_t op_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         pop_i,
  output tcw_pkg::op_t op_o
);
  import tcw_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  op_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// ===== src/tcw_back.sv =====
// Back part of the console writer: screen memory, cursor, sweeps and result register.
// Depends on tcw_pkg; takes operations from tcw_queue.
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         op_valid_i,
  input  tcw_pkg::op_t op_i,
  output logic         pop_o,
  output logic         init_busy_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [6:0]   cursor_col_o,
  output logic [4:0]   cursor_row_o,
  output logic [7:0]   read_char_o,
  output logic [7:0]   read_attr_o,
  output logic         did_scroll_o
);
  import tcw_pkg::*;

  localparam int CW       = $clog2(COLUMNS);
  localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW       = RW + CW;
  localparam int MemDepth = ROWS << CW;

  typedef enum logic [5:0] {
    S_INIT    = 6'b000001,
    S_IDLE    = 6'b000010,
    S_FILL    = 6'b000100,
    S_SCRL_RD = 6'b001000,
    S_SCRL_WR = 6'b010000,
    S_RESP    = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   col_q, col_d, sc_q, sc_d;
  logic [RW-1:0]   row_q, row_d, sr_q, sr_d;
  logic [15:0]     fill_q, fill_d;
  logic            scrolled_q, scrolled_d;
  logic            is_read_q, is_read_d;

  logic [15:0]     mem_q [MemDepth];
  logic [15:0]     rdata_q;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [15:0]     wdata;

  logic            load_out;
  logic            last_col, last_row, scroll_last;
  logic [CW:0]     col_inc;
  logic [7:0]      tab_col;
  logic signed [9:0] nx, ny;

  assign last_col    = (sc_q == CW'(COLUMNS - 1));
  assign last_row    = (sr_q == RW'(ROWS - 1));
  assign scroll_last = last_col && (sr_q == RW'(ROWS - 2));
  assign col_inc     = {1'b0, col_q} + 1'b1;
  assign tab_col     = (8'(col_q) + 8'd8) & TAB_MASK;
  assign nx          = signed'(10'(col_q)) + 10'(op_i.dx);
  assign ny          = signed'(10'(row_q)) + 10'(op_i.dy);
  assign load_out    = (state_q == S_RESP) && (!out_valid_o || !out_stall_i);
  assign init_busy_o = (state_q == S_INIT);
  assign pop_o       = (state_q == S_IDLE) && op_valid_i;

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    sc_d       = sc_q;
    sr_d       = sr_q;
    fill_d     = fill_q;
    scrolled_d = scrolled_q;
    is_read_d  = is_read_q;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = {sr_q, sc_q};
    wdata      = fill_q;
    raddr      = {sr_q + 1'b1, sc_q};
    unique case (state_q)
      S_INIT, S_FILL: begin
        we = 1'b1;
        sc_d = last_col ? '0 : sc_q + 1'b1;
        if (last_col) begin
          sr_d = sr_q + 1'b1;
        end
        if (last_col && last_row) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        if (op_valid_i) begin
          state_d    = S_RESP;
          scrolled_d = 1'b0;
          is_read_d  = 1'b0;
          fill_d     = {op_i.attr, CH_SPACE};
          sr_d       = '0;
          sc_d       = '0;
          case (op_i.kind)
            K_PRINT, K_NEWLINE, K_TAB: begin
              if (op_i.kind == K_PRINT) begin
                we    = 1'b1;
                waddr = {row_q, col_q};
                wdata = {op_i.attr, op_i.ch};
              end
              if ((op_i.kind == K_NEWLINE) ||
                  (op_i.kind == K_PRINT && col_inc >= (CW + 1)'(COLUMNS)) ||
                  (op_i.kind == K_TAB && tab_col >= 8'(COLUMNS))) begin
                col_d = '0;
                if (row_q == RW'(ROWS - 1)) begin
                  scrolled_d = 1'b1;
                  state_d    = S_SCRL_RD;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end else if (op_i.kind == K_PRINT) begin
                col_d = col_inc[CW-1:0];
              end else begin
                col_d = tab_col[CW-1:0];
              end
            end
            K_RETURN: col_d = '0;
            K_BACKSPACE: begin
              if (col_q != '0) begin
                col_d = col_q - 1'b1;
                we    = 1'b1;
                waddr = {row_q, col_q - 1'b1};
                wdata = {op_i.attr, CH_SPACE};
              end
            end
            K_PUT_POS: begin
              we    = 1'b1;
              waddr = {op_i.y[RW-1:0], op_i.x[CW-1:0]};
              wdata = {op_i.attr, op_i.ch};
            end
            K_SET: begin
              col_d = op_i.x[CW-1:0];
              row_d = op_i.y[RW-1:0];
            end
            K_MOVE: begin
              if (!nx[9] && !ny[9] && nx < 10'sd0 + 10'(COLUMNS) &&
                  ny < 10'sd0 + 10'(ROWS)) begin
                col_d = nx[CW-1:0];
                row_d = ny[RW-1:0];
              end
            end
            K_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              state_d = S_FILL;
            end
            K_SCROLL: begin
              if (row_q != '0) begin
                row_d = row_q - 1'b1;
              end
              scrolled_d = 1'b1;
              state_d    = S_SCRL_RD;
            end
            K_READ: begin
              re        = 1'b1;
              raddr     = {op_i.y[RW-1:0], op_i.x[CW-1:0]};
              is_read_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCRL_RD: begin
        re      = 1'b1;
        state_d = S_SCRL_WR;
      end
      S_SCRL_WR: begin
        we    = 1'b1;
        wdata = rdata_q;
        sc_d  = last_col ? '0 : sc_q + 1'b1;
        if (scroll_last) begin
          sr_d    = RW'(ROWS - 1);
          state_d = S_FILL;
        end else begin
          if (last_col) begin
            sr_d = sr_q + 1'b1;
          end
          state_d = S_SCRL_RD;
        end
      end
      S_RESP: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      col_q       <= '0;
      row_q       <= '0;
      sc_q        <= '0;
      sr_q        <= '0;
      fill_q      <= '0;
      scrolled_q  <= 1'b0;
      is_read_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      sc_q       <= sc_d;
      sr_q       <= sr_d;
      fill_q     <= fill_d;
      scrolled_q <= scrolled_d;
      is_read_q  <= is_read_d;
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      cursor_col_o <= 7'(col_q);
      cursor_row_o <= 5'(row_q);
      read_char_o  <= is_read_q ? rdata_q[7:0] : 8'h00;
      read_attr_o  <= is_read_q ? rdata_q[15:8] : 8'h00;
      did_scroll_o <= scrolled_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

endmodule

// ===== src/text_console_char_writer.sv =====
// Text console character writer: a character screen with cursor, driven one item at a time.
// An ordinary put, set, move or read passes from the queue through S_RESP to the result register.
// Clear fills every cell in S_FILL; scroll copies each row up through S_SCRL_RD and S_SCRL_WR,
// reading a cell and then writing it, and then fills the last row in S_FILL.
// After reset a clearing pass in S_INIT zeroes the screen; no item is taken then.
// A two-entry queue lets the front accept items while the back is busy.
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        func_i,
  input  logic [7:0]        ch_i,
  input  logic [7:0]        attr_i,
  input  logic [7:0]        col_x_i,
  input  logic [7:0]        row_y_i,
  input  logic signed [7:0] delta_x_i,
  input  logic signed [7:0] delta_y_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [6:0]        cursor_col_o,
  output logic [4:0]        cursor_row_o,
  output logic [7:0]        read_char_o,
  output logic [7:0]        read_attr_o,
  output logic              did_scroll_o
);
  import tcw_pkg::*;

  op_t  front_op, queue_op;
  logic push, pop, queue_full, queue_valid, init_busy;

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .ch_i        (ch_i),
    .attr_i      (attr_i),
    .col_x_i     (col_x_i),
    .row_y_i     (row_y_i),
    .delta_x_i   (delta_x_i),
    .delta_y_i   (delta_y_i),
    .queue_full_i(queue_full),
    .init_busy_i (init_busy),
    .push_o      (push),
    .op_o        (front_op)
  );

  tcw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (front_op),
    .full_o (queue_full),
    .valid_o(queue_valid),
    .pop_i  (pop),
    .op_o   (queue_op)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (queue_valid),
    .op_i        (queue_op),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .read_char_o (read_char_o),
    .read_attr_o (read_attr_o),
    .did_scroll_o(did_scroll_o)
  );

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(cursor_col_o) < COLUMNS) && (32'(cursor_row_o) < ROWS))
    else $error("Reported cursor lies outside the screen.");

  a_scroll_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && did_scroll_o) |-> (read_char_o == 8'h00) && (read_attr_o == 8'h00))
    else $error("A scrolling item reported read data.");

  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> (!out_valid_o && !queue_valid))
    else $error("Work seen during the clearing pass.");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the text console character writer.
// Depends on tcw_pkg for the character and function codes, and on text_console_char_writer.
// A screen predictor runs beside the block, and every result is checked against its output.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 20;
  localparam int TEXT_ITEMS = 700;
  localparam int MIX_ITEMS = 810;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic [2:0]        func;
    logic [7:0]        ch;
    logic [7:0]        attr;
    logic [7:0]        col_x;
    logic [7:0]        row_y;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
  } console_item_t;

  typedef struct packed {
    logic [6:0] col;
    logic [4:0] row;
    logic [7:0] rd_char;
    logic [7:0] rd_attr;
    logic       scrolled;
  } console_report_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [2:0]        func_i = '0;
  logic [7:0]        ch_i = '0;
  logic [7:0]        attr_i = '0;
  logic [7:0]        col_x_i = '0;
  logic [7:0]        row_y_i = '0;
  logic signed [7:0] delta_x_i = '0;
  logic signed [7:0] delta_y_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [6:0]        cursor_col_o;
  logic [4:0]        cursor_row_o;
  logic [7:0]        read_char_o;
  logic [7:0]        read_attr_o;
  logic              did_scroll_o;

  text_console_char_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .ch_i        (ch_i),
    .attr_i      (attr_i),
    .col_x_i     (col_x_i),
    .row_y_i     (row_y_i),
    .delta_x_i   (delta_x_i),
    .delta_y_i   (delta_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .read_char_o (read_char_o),
    .read_attr_o (read_attr_o),
    .did_scroll_o(did_scroll_o)
  );

  logic [15:0]     screen_img [CELL_COUNT];
  int              model_col;
  int              model_row;
  console_report_t pending_reports [$];
  int              fail_count = 0;
  int              reports_checked = 0;
  int              scroll_reports = 0;
  int              items_sent = 0;
  int              func_count [8];
  int              burst_left = 0;
  bit              sender_gaps = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void scroll_screen(input logic [7:0] colour);
    for (int i = 0; i + COLUMNS < CELL_COUNT; i++) screen_img[i] = screen_img[i + COLUMNS];
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen_img[i] = {colour, CH_SPACE};
    if (model_row > 0) model_row--;
  endfunction

  function automatic logic line_feed(input logic [7:0] colour);
    model_col = 0;
    model_row++;
    if (model_row >= ROWS) begin
      scroll_screen(colour);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void put_cell(input int x, input int y, input logic [7:0] c,
                                   input logic [7:0] colour);
    if (x < COLUMNS && y < ROWS) screen_img[y * COLUMNS + x] = {colour, c};
  endfunction

  function automatic console_report_t predict_screen_op(input console_item_t it);
    console_report_t rep;
    int nx;
    int ny;
    logic [15:0] cell_word;
    rep = '0;
    case (it.func)
      FN_PUT: begin
        if (it.ch == CH_NEWLINE) begin
          rep.scrolled = line_feed(it.attr);
        end else if (it.ch == CH_RETURN) begin
          model_col = 0;
        end else if (it.ch == CH_TAB) begin
          model_col = (model_col + 8) & ~7;
          if (model_col >= COLUMNS) rep.scrolled = line_feed(it.attr);
        end else if (it.ch == CH_BACKSPACE) begin
          if (model_col > 0) begin
            model_col--;
            put_cell(model_col, model_row, CH_SPACE, it.attr);
          end
        end else begin
          put_cell(model_col, model_row, it.ch, it.attr);
          model_col++;
          if (model_col >= COLUMNS) rep.scrolled = line_feed(it.attr);
        end
      end
      FN_PUT_POS: put_cell(it.col_x, it.row_y, it.ch, it.attr);
      FN_SET: begin
        if (it.col_x < COLUMNS && it.row_y < ROWS) begin
          model_col = it.col_x;
          model_row = it.row_y;
        end
      end
      FN_MOVE: begin
        nx = model_col + int'(it.delta_x);
        ny = model_row + int'(it.delta_y);
        if (nx >= 0 && nx < COLUMNS && ny >= 0 && ny < ROWS) begin
          model_col = nx;
          model_row = ny;
        end
      end
      FN_CLEAR: begin
        foreach (screen_img[i]) screen_img[i] = {it.attr, CH_SPACE};
        model_col = 0;
        model_row = 0;
      end
      FN_SCROLL: begin
        scroll_screen(it.attr);
        rep.scrolled = 1'b1;
      end
      FN_READ: begin
        if (it.col_x < COLUMNS && it.row_y < ROWS) begin
          cell_word = screen_img[it.row_y * COLUMNS + it.col_x];
          rep.rd_char = cell_word[7:0];
          rep.rd_attr = cell_word[15:8];
        end
      end
      default: ;
    endcase
    rep.col = 7'(model_col);
    rep.row = 5'(model_row);
    return rep;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTED) $display("%0t ns: %s", $realtime, msg);
  endfunction

  function automatic console_item_t console_op(input logic [2:0] func, input logic [7:0] ch,
                                               input logic [7:0] attr, input logic [7:0] x,
                                               input logic [7:0] y,
                                               input logic signed [7:0] dx,
                                               input logic signed [7:0] dy);
    console_item_t it;
    it.func = func;
    it.ch = ch;
    it.attr = attr;
    it.col_x = x;
    it.row_y = y;
    it.delta_x = dx;
    it.delta_y = dy;
    return it;
  endfunction

  function automatic console_item_t random_item();
    console_item_t it;
    it.func = 3'($urandom_range(0, 7));
    it.ch = 8'($urandom_range(0, 255));
    it.attr = 8'($urandom_range(0, 255));
    it.col_x = 8'($urandom_range(0, 255));
    it.row_y = 8'($urandom_range(0, 255));
    it.delta_x = 8'($urandom_range(0, 255));
    it.delta_y = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic logic [7:0] pick_col();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(0, COLUMNS - 1));
    if (r == 7) return ($urandom_range(0, 1) == 1) ? 8'(COLUMNS - 1) : 8'(COLUMNS);
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_row();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(0, ROWS - 1));
    if (r == 7) return ($urandom_range(0, 1) == 1) ? 8'(ROWS - 1) : 8'(ROWS);
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 92) begin
      case ($urandom_range(0, 3))
        0: return CH_NEWLINE;
        1: return CH_RETURN;
        2: return CH_TAB;
        default: return CH_BACKSPACE;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input console_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i <= it.func;
    ch_i <= it.ch;
    attr_i <= it.attr;
    col_x_i <= it.col_x;
    row_y_i <= it.row_y;
    delta_x_i <= it.delta_x;
    delta_y_i <= it.delta_y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_reports.push_back(predict_screen_op(it));
    items_sent++;
    func_count[it.func]++;
  endtask

  task automatic test_put_controls();
    send_item(console_op(FN_PUT, 8'h41, 8'h1F, 8'd0, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_PUT, CH_BACKSPACE, 8'h2E, 8'd0, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_PUT, CH_BACKSPACE, 8'h3D, 8'd0, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_PUT, CH_TAB, 8'h00, 8'd0, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_PUT, CH_RETURN, 8'h00, 8'd0, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_PUT, CH_NEWLINE, 8'h00, 8'd0, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_READ, 8'h00, 8'h00, 8'd0, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_SET, 8'h00, 8'h00, 8'd79, 8'd24, 8'sd0, 8'sd0));
    send_item(console_op(FN_PUT, 8'hFF, 8'hFF, 8'd0, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_READ, 8'h00, 8'h00, 8'd79, 8'd23, 8'sd0, 8'sd0));
    send_item(console_op(FN_SET, 8'h00, 8'h00, 8'd75, 8'd24, 8'sd0, 8'sd0));
    send_item(console_op(FN_PUT, CH_TAB, 8'h5A, 8'd0, 8'd0, 8'sd0, 8'sd0));
  endtask

  task automatic test_range_checks();
    send_item(console_op(FN_PUT_POS, 8'h00, 8'h00, 8'd79, 8'd24, 8'sd0, 8'sd0));
    send_item(console_op(FN_PUT_POS, 8'h7E, 8'hC3, 8'd255, 8'd255, 8'sd0, 8'sd0));
    send_item(console_op(FN_READ, 8'h00, 8'h00, 8'd80, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_READ, 8'h00, 8'h00, 8'd79, 8'd24, 8'sd0, 8'sd0));
    send_item(console_op(FN_SET, 8'h00, 8'h00, 8'd80, 8'd3, 8'sd0, 8'sd0));
    send_item(console_op(FN_SET, 8'h00, 8'h00, 8'd0, 8'd25, 8'sd0, 8'sd0));
    send_item(console_op(FN_MOVE, 8'h00, 8'h00, 8'd0, 8'd0, 8'sh80, 8'sd0));
    send_item(console_op(FN_MOVE, 8'h00, 8'h00, 8'd0, 8'd0, 8'sh7F, 8'sh7F));
    send_item(console_op(FN_MOVE, 8'h00, 8'h00, 8'd0, 8'd0, 8'sd5, -8'sd3));
  endtask

  task automatic test_screen_ops();
    send_item(console_op(FN_SCROLL, 8'h00, 8'h71, 8'd0, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_SET, 8'h00, 8'h00, 8'd0, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_SCROLL, 8'h00, 8'h17, 8'd0, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_CLEAR, 8'h00, 8'hA5, 8'd0, 8'd0, 8'sd0, 8'sd0));
    send_item(console_op(FN_UNUSED, 8'hFF, 8'hFF, 8'd255, 8'd255, 8'shFF, 8'shFF));
    send_item(console_op(FN_SET, 8'h00, 8'h00, 8'd10, 8'd24, 8'sd0, 8'sd0));
    send_item(console_op(FN_PUT, CH_NEWLINE, 8'h4B, 8'd0, 8'd0, 8'sd0, 8'sd0));
  endtask

  task automatic test_random_text();
    console_item_t it;
    int r;
    for (int n = 0; n < TEXT_ITEMS; n++) begin
      it = random_item();
      r = $urandom_range(0, 99);
      if (r < 55) begin
        it.func = FN_PUT;
        it.ch = text_char();
      end else if (r < 59) begin
        it.func = FN_PUT;
        it.ch = CH_NEWLINE;
      end else if (r < 74) begin
        it.func = FN_READ;
        if (r < 68) begin
          it.col_x = (model_col > 0) ? 8'(model_col - 1) : 8'd0;
          it.row_y = 8'(model_row);
        end else begin
          it.col_x = pick_col();
          it.row_y = pick_row();
        end
      end else if (r < 82) begin
        it.func = FN_SET;
        if (r < 78) begin
          it.col_x = 8'($urandom_range(COLUMNS - 10, COLUMNS - 1));
          it.row_y = 8'($urandom_range(ROWS - 4, ROWS - 1));
        end else begin
          it.col_x = pick_col();
          it.row_y = pick_row();
        end
      end else if (r < 88) begin
        it.func = FN_MOVE;
        it.delta_x = 8'($urandom_range(0, 8) - 4);
        it.delta_y = 8'($urandom_range(0, 4) - 2);
      end else if (r < 95) begin
        it.func = FN_PUT_POS;
        it.col_x = pick_col();
        it.row_y = pick_row();
      end else if (r < 97) begin
        it.func = FN_SCROLL;
      end else if (r < 98) begin
        it.func = FN_CLEAR;
      end
      send_item(it);
    end
  endtask

  task automatic test_drained_restart();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 12;
    for (int n = 0; n < 12; n++) begin
      send_item(console_op(FN_READ, 8'h00, 8'h00, 8'(n), 8'(ROWS - 1), 8'sd0, 8'sd0));
    end
  endtask

  task automatic test_random_mix();
    console_item_t it;
    int r;
    for (int n = 0; n < MIX_ITEMS; n++) begin
      sender_gaps = (n >= 150);
      it = random_item();
      r = $urandom_range(0, 99);
      if (r < 20) begin
        it.func = FN_PUT;
        if (r < 12) it.ch = text_char();
      end else if (r < 32) begin
        it.func = FN_PUT_POS;
        it.col_x = pick_col();
        it.row_y = pick_row();
      end else if (r < 44) begin
        it.func = FN_SET;
        it.col_x = pick_col();
        it.row_y = pick_row();
      end else if (r < 58) begin
        it.func = FN_MOVE;
        if (r < 51) begin
          it.delta_x = 8'($urandom_range(0, 40) - 20);
          it.delta_y = 8'($urandom_range(0, 10) - 5);
        end
      end else if (r < 59) begin
        it.func = FN_CLEAR;
      end else if (r < 61) begin
        it.func = FN_SCROLL;
      end else if (r < 94) begin
        it.func = FN_READ;
        it.col_x = pick_col();
        it.row_y = pick_row();
      end else begin
        it.func = FN_UNUSED;
      end
      send_item(it);
    end
    sender_gaps = 1'b1;
  endtask

  initial begin : receiver_stall
    int mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 9) < 7);
          default: out_stall_i <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    console_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reports_checked++;
      if (did_scroll_o) scroll_reports++;
      if (pending_reports.size() == 0) begin
        note_failure($sformatf("result with nothing expected: col %0d row %0d char %02h attr %02h scroll %0b",
                               cursor_col_o, cursor_row_o, read_char_o, read_attr_o,
                               did_scroll_o));
      end else begin
        want = pending_reports.pop_front();
        if (cursor_col_o !== want.col || cursor_row_o !== want.row ||
            read_char_o !== want.rd_char || read_attr_o !== want.rd_attr ||
            did_scroll_o !== want.scrolled) begin
          note_failure($sformatf({"mismatch: expected col %0d row %0d char %02h attr %02h ",
                                  "scroll %0b, got col %0d row %0d char %02h attr %02h scroll %0b"},
                                 want.col, want.row, want.rd_char, want.rd_attr, want.scrolled,
                                 cursor_col_o, cursor_row_o, read_char_o, read_attr_o,
                                 did_scroll_o));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("No handshake for %0d cycles, %0d results still outstanding.", QUIET_LIMIT,
             pending_reports.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    foreach (screen_img[i]) screen_img[i] = '0;
    foreach (func_count[i]) func_count[i] = 0;
    model_col = 0;
    model_row = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_put_controls();
    test_range_checks();
    test_screen_ops();
    test_random_text();
    test_drained_restart();
    test_random_mix();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items: %0d puts, %0d positioned puts, %0d sets, %0d moves, %0d clears,",
             items_sent, func_count[FN_PUT], func_count[FN_PUT_POS], func_count[FN_SET],
             func_count[FN_MOVE], func_count[FN_CLEAR]);
    $display("%0d scroll ops, %0d reads, %0d unused codes; %0d results checked, %0d scrolled.",
             func_count[FN_SCROLL], func_count[FN_READ], func_count[FN_UNUSED],
             reports_checked, scroll_reports);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures in total.", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
